/* src/rational_arithmetic_unit_defines.svh */
// assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, prop) lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
    prop) else $error("%m: assertion failed");
`define RAU_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge aclk) \
    disable iff (!aresetn) (ante) |=> (cons)) else $error("%m: assertion failed");
`else
`define RAU_ASSERT(lbl, prop)
`define RAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/rau_pkg.sv */
// shared types and constants of the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam int VALUE_BITS_DEF = 32;
    localparam int ACTION_BITS    = 4;
    localparam int OPER_BITS      = 32;
    localparam int NUM_BITS       = 32;
    localparam int DEN_BITS       = 31;

    localparam logic [ACTION_BITS-1:0] ACT_ADD = 4'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SUB = 4'd1;
    localparam logic [ACTION_BITS-1:0] ACT_MUL = 4'd2;
    localparam logic [ACTION_BITS-1:0] ACT_DIV = 4'd3;
    localparam logic [ACTION_BITS-1:0] ACT_EQ  = 4'd4;
    localparam logic [ACTION_BITS-1:0] ACT_LT  = 4'd5;
    localparam logic [ACTION_BITS-1:0] ACT_LE  = 4'd6;
    localparam logic [ACTION_BITS-1:0] ACT_GT  = 4'd7;
    localparam logic [ACTION_BITS-1:0] ACT_GE  = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMBINE,
        ST_GCD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;
endpackage
`default_nettype wire

/* src/rau_mul.sv */
// registered unsigned multiplier shared by all products
`default_nettype none
module rau_mul #(
    parameter int WIDTH = rau_pkg::VALUE_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic [WIDTH-1:0]   a,
    input  wire logic [WIDTH-1:0]   b,
    output logic      [2*WIDTH-1:0] prod
);
    logic [2*WIDTH-1:0] prod_reg;
    logic [2*WIDTH-1:0] prod_next;

    assign prod_next = (2*WIDTH)'(a) * (2*WIDTH)'(b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

/* src/rau_div.sv */
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module rau_div #(
    parameter int WIDTH = 2 * rau_pkg::VALUE_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [WIDTH-1:0]     dividend,
    input  wire logic [WIDTH-1:0]     divisor,
    output logic      [WIDTH-1:0]     quotient,
    output rau_pkg::div_status_t      status
);
    localparam int CW = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = !diff[WIDTH];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;
endmodule
`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// top level of the rational arithmetic unit: sequencer, gcd and result register
//
// Takes one request of two fractions and an action, gives one result. The three
// products go one after another through a single registered multiplier; arithmetic
// results are reduced by a binary gcd (one subtract or shift per cycle) and then
// by two restoring dividers run side by side. A comparison or a zero result skips
// the gcd and the dividers, and a flagged request also skips the multiplier.
// s_ready is high only between requests; a finished result waits in the output
// register.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
    parameter int VALUE_BITS = rau_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [rau_pkg::ACTION_BITS-1:0]   s_action,
    input  wire logic [rau_pkg::OPER_BITS-1:0]     s_first_numerator,
    input  wire logic [rau_pkg::OPER_BITS-1:0]     s_first_denominator,
    input  wire logic [rau_pkg::OPER_BITS-1:0]     s_second_numerator,
    input  wire logic [rau_pkg::OPER_BITS-1:0]     s_second_denominator,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [rau_pkg::NUM_BITS-1:0]      m_result_numerator,
    output logic      [rau_pkg::DEN_BITS-1:0]      m_result_denominator,
    output logic                                   m_compare_true,
    output logic                                   m_zero_denominator,
    output logic                                   m_overflow
);
    localparam int VB = VALUE_BITS;
    localparam int W2 = 2 * VALUE_BITS;
    localparam int KW = $clog2(W2);
    localparam int NB = rau_pkg::NUM_BITS;
    localparam int DB = rau_pkg::DEN_BITS;
    localparam logic [W2-1:0] LIM    = {{(W2-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);
    localparam logic [W2-1:0] LIM_M1 = LIM - 1'b1;

    rau_pkg::state_t state_reg, state_next;

    logic [rau_pkg::ACTION_BITS-1:0] act_reg, act_next;
    logic [VB-1:0] n1_reg, n1_next, d1_reg, d1_next, n2_reg, n2_next, d2_reg, d2_next;
    logic          s1_reg, s1_next, s2_reg, s2_next, sn_reg, sn_next;
    logic [W2-1:0] p_reg, p_next, q_reg, q_next, r_reg, r_next;
    logic [W2-1:0] num_reg, num_next, den_reg, den_next;
    logic [W2-1:0] ga_reg, ga_next, gb_reg, gb_next, g_reg, g_next;
    logic [KW-1:0] gk_reg, gk_next;
    logic [NB-1:0] res_num_reg, res_num_next;
    logic [DB-1:0] res_den_reg, res_den_next;
    logic          res_cmp_reg, res_cmp_next, res_zf_reg, res_zf_next;
    logic          res_ovf_reg, res_ovf_next;
    logic          m_valid_reg, m_valid_next;
    logic [NB-1:0] m_num_reg, m_num_next;
    logic [DB-1:0] m_den_reg, m_den_next;
    logic          m_cmp_reg, m_cmp_next, m_zf_reg, m_zf_next, m_ovf_reg, m_ovf_next;

    // operand sign and magnitude
    logic [VB-1:0] in_n1, in_d1, in_n2, in_d2;
    logic [VB-1:0] mag_n1, mag_d1, mag_n2, mag_d2;

    assign in_n1  = s_first_numerator[VB-1:0];
    assign in_d1  = s_first_denominator[VB-1:0];
    assign in_n2  = s_second_numerator[VB-1:0];
    assign in_d2  = s_second_denominator[VB-1:0];
    assign mag_n1 = in_n1[VB-1] ? (~in_n1 + 1'b1) : in_n1;
    assign mag_d1 = in_d1[VB-1] ? (~in_d1 + 1'b1) : in_d1;
    assign mag_n2 = in_n2[VB-1] ? (~in_n2 + 1'b1) : in_n2;
    assign mag_d2 = in_d2[VB-1] ? (~in_d2 + 1'b1) : in_d2;

    // shared multiplier
    logic [VB-1:0] mul_a, mul_b;
    logic [W2-1:0] mul_prod;

    rau_mul #(.WIDTH(VB)) u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // reducing dividers
    logic                 div_start;
    logic [W2-1:0]        qn, qd;
    rau_pkg::div_status_t dstat_n, dstat_d;

    rau_div #(.WIDTH(W2)) u_div_num (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (g_reg),
        .quotient (qn),
        .status   (dstat_n)
    );

    rau_div #(.WIDTH(W2)) u_div_den (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (den_reg),
        .divisor  (g_reg),
        .quotient (qd),
        .status   (dstat_d)
    );

    // compare and combine
    logic          an, bn, c_eq, c_lt, sq;
    logic [W2-1:0] comb_num;
    logic          comb_sn;

    assign an   = s1_reg && (p_reg != '0);
    assign bn   = s2_reg && (q_reg != '0);
    assign c_eq = (an == bn) && (p_reg == q_reg);
    assign c_lt = (an != bn) ? an : (an ? (p_reg > q_reg) : (p_reg < q_reg));
    assign sq   = (act_reg == rau_pkg::ACT_SUB) ? !s2_reg : s2_reg;

    always_comb begin
        comb_num = p_reg;
        comb_sn  = s1_reg ^ s2_reg;
        if (act_reg == rau_pkg::ACT_ADD || act_reg == rau_pkg::ACT_SUB) begin
            priority if (s1_reg == sq) begin
                comb_num = p_reg + q_reg;
                comb_sn  = s1_reg;
            end else if (p_reg >= q_reg) begin
                comb_num = p_reg - q_reg;
                comb_sn  = s1_reg;
            end else begin
                comb_num = q_reg - p_reg;
                comb_sn  = sq;
            end
        end
    end

    // reduced result
    logic [W2-1:0] sval;
    logic          bad;

    assign sval = sn_reg ? (~qn + 1'b1) : qn;
    assign bad  = (qd > LIM_M1) || (sn_reg ? (qn > LIM) : (qn > LIM_M1));

    always_comb begin
        state_next   = state_reg;
        act_next     = act_reg;
        n1_next      = n1_reg;
        d1_next      = d1_reg;
        n2_next      = n2_reg;
        d2_next      = d2_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        sn_next      = sn_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        r_next       = r_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        gk_next      = gk_reg;
        g_next       = g_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_cmp_next = res_cmp_reg;
        res_zf_next  = res_zf_reg;
        res_ovf_next = res_ovf_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_cmp_next   = m_cmp_reg;
        m_zf_next    = m_zf_reg;
        m_ovf_next   = m_ovf_reg;
        mul_a        = n1_reg;
        mul_b        = d2_reg;
        div_start    = 1'b0;

        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    act_next   = s_action;
                    n1_next    = mag_n1;
                    d1_next    = mag_d1;
                    n2_next    = mag_n2;
                    d2_next    = mag_d2;
                    s1_next    = in_n1[VB-1] ^ in_d1[VB-1];
                    s2_next    = in_n2[VB-1] ^ in_d2[VB-1];
                    state_next = rau_pkg::ST_CHECK;
                end
            end
            rau_pkg::ST_CHECK: begin
                res_num_next = '0;
                res_den_next = DB'(1);
                res_cmp_next = 1'b0;
                res_zf_next  = 1'b0;
                res_ovf_next = 1'b0;
                priority if (act_reg > rau_pkg::ACT_GE) begin
                    state_next = rau_pkg::ST_DONE;
                end else if (d1_reg == '0 || d2_reg == '0 ||
                             (act_reg == rau_pkg::ACT_DIV && n2_reg == '0)) begin
                    res_zf_next = 1'b1;
                    state_next  = rau_pkg::ST_DONE;
                end else begin
                    state_next = rau_pkg::ST_MUL0;
                end
            end
            rau_pkg::ST_MUL0: begin
                mul_a      = n1_reg;
                mul_b      = (act_reg == rau_pkg::ACT_MUL) ? n2_reg : d2_reg;
                state_next = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                mul_a      = n2_reg;
                mul_b      = d1_reg;
                p_next     = mul_prod;
                state_next = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                mul_a      = d1_reg;
                mul_b      = (act_reg == rau_pkg::ACT_DIV) ? n2_reg : d2_reg;
                q_next     = mul_prod;
                state_next = rau_pkg::ST_MUL3;
            end
            rau_pkg::ST_MUL3: begin
                r_next     = mul_prod;
                state_next = rau_pkg::ST_COMBINE;
            end
            rau_pkg::ST_COMBINE: begin
                if (act_reg >= rau_pkg::ACT_EQ) begin
                    unique case (act_reg)
                        rau_pkg::ACT_EQ: res_cmp_next = c_eq;
                        rau_pkg::ACT_LT: res_cmp_next = c_lt;
                        rau_pkg::ACT_LE: res_cmp_next = c_lt || c_eq;
                        rau_pkg::ACT_GT: res_cmp_next = !c_lt && !c_eq;
                        rau_pkg::ACT_GE: res_cmp_next = !c_lt;
                        default:         res_cmp_next = 1'b0;
                    endcase
                    state_next = rau_pkg::ST_DONE;
                end else if (comb_num == '0) begin
                    state_next = rau_pkg::ST_DONE;
                end else begin
                    num_next   = comb_num;
                    den_next   = r_reg;
                    sn_next    = comb_sn;
                    ga_next    = comb_num;
                    gb_next    = r_reg;
                    gk_next    = '0;
                    state_next = rau_pkg::ST_GCD;
                end
            end
            rau_pkg::ST_GCD: begin
                priority if (ga_reg == '0) begin
                    g_next     = gb_reg << gk_reg;
                    state_next = rau_pkg::ST_DIV_START;
                end else if (gb_reg == '0) begin
                    g_next     = ga_reg << gk_reg;
                    state_next = rau_pkg::ST_DIV_START;
                end else if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end else if (!ga_reg[0]) begin
                    ga_next = ga_reg >> 1;
                end else if (!gb_reg[0]) begin
                    gb_next = gb_reg >> 1;
                end else if (ga_reg >= gb_reg) begin
                    ga_next = ga_reg - gb_reg;
                end else begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            rau_pkg::ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = rau_pkg::ST_DIV_WAIT;
            end
            rau_pkg::ST_DIV_WAIT: begin
                if (dstat_n.done && dstat_d.done) begin
                    if (bad) begin
                        res_ovf_next = 1'b1;
                    end else begin
                        res_num_next = NB'($signed(sval[VB-1:0]));
                        res_den_next = DB'(qd[VB-2:0]);
                    end
                    state_next = rau_pkg::ST_DONE;
                end
            end
            rau_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_num_next   = res_num_reg;
                    m_den_next   = res_den_reg;
                    m_cmp_next   = res_cmp_reg;
                    m_zf_next    = res_zf_reg;
                    m_ovf_next   = res_ovf_reg;
                    state_next   = rau_pkg::ST_IDLE;
                end
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg     <= act_next;
        n1_reg      <= n1_next;
        d1_reg      <= d1_next;
        n2_reg      <= n2_next;
        d2_reg      <= d2_next;
        s1_reg      <= s1_next;
        s2_reg      <= s2_next;
        sn_reg      <= sn_next;
        p_reg       <= p_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        gk_reg      <= gk_next;
        g_reg       <= g_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_cmp_reg <= res_cmp_next;
        res_zf_reg  <= res_zf_next;
        res_ovf_reg <= res_ovf_next;
        m_num_reg   <= m_num_next;
        m_den_reg   <= m_den_next;
        m_cmp_reg   <= m_cmp_next;
        m_zf_reg    <= m_zf_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign s_ready              = (state_reg == rau_pkg::ST_IDLE);
    assign m_valid              = m_valid_reg;
    assign m_result_numerator   = m_num_reg;
    assign m_result_denominator = m_den_reg;
    assign m_compare_true       = m_cmp_reg;
    assign m_zero_denominator   = m_zf_reg;
    assign m_overflow           = m_ovf_reg;

    `RAU_ASSERT_NEXT(a_accept_check, s_valid && s_ready, state_reg == rau_pkg::ST_CHECK)
    `RAU_ASSERT(a_den_nonzero, m_valid |-> m_result_denominator != '0)
    `RAU_ASSERT(a_flags_excl, m_valid |-> !(m_zero_denominator && (m_compare_true || m_overflow)))
    `RAU_ASSERT(a_ovf_unit, m_valid && m_overflow |-> m_result_numerator == '0)
endmodule
`default_nettype wire
